@@ rtl/gfe_pkg.sv @@
// Shared types, constants and the arctangent table for the GNSS fix to local ENU block.
package gfe_pkg;

	// Width of the shared step counter (covers up to 32 CORDIC steps).
	localparam int IDX_W = 5;
	localparam int CORDIC_STEPS_DEF = 24;

	// Input item kinds.
	localparam logic [1:0] KIND_SOL = 2'd1;
	localparam logic [1:0] KIND_RST = 2'd2;

	// Lowest fix type that counts as a 3D fix.
	localparam logic [2:0] FIX_3D = 3'd3;

	// Fixed-point constants.
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [30:0] LAT_FULL = 31'd1800000000;
	localparam logic [61:0] LAT_HALF = 62'd900000000;
	localparam logic [29:0] LAT_MAX = 30'd900000000;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;
	localparam logic [36:0] K_MM_Q32 = 37'd47811357236;

	// Reciprocal of the half-turn constant, floor(2^62 / LAT_FULL).
	localparam logic [31:0] LAT_RECIP = 32'd2562047788;

	// Result selection.
	localparam logic [1:0] RES_ZERO = 2'd0;
	localparam logic [1:0] RES_TIME = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;

	// Shared multiplier operations.
	localparam logic [1:0] MOP_G = 2'd0;
	localparam logic [1:0] MOP_E = 2'd1;
	localparam logic [1:0] MOP_N = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load_in;
		logic             clear;
		logic             set_prev;
		logic             latch_origin;
		logic             div_start;
		logic             div_step;
		logic             cord_step;
		logic             cos_load;
		logic             mul_step;
		logic [1:0]       mul_op;
		logic [IDX_W-1:0] idx;
		logic [1:0]       res;
		logic             out_load;
	} gfe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] kind;
		logic       tow_same;
		logic       fix_3d;
		logic       origin_set;
	} gfe_stat_t;

	// Arctangent of 2^-i in Q2.30.
	function automatic logic [33:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [33:0] a;
		case (i)
			5'd0:  a = 34'd843314857;
			5'd1:  a = 34'd497837829;
			5'd2:  a = 34'd263043837;
			5'd3:  a = 34'd133525159;
			5'd4:  a = 34'd67021687;
			5'd5:  a = 34'd33543516;
			5'd6:  a = 34'd16775851;
			5'd7:  a = 34'd8388437;
			5'd8:  a = 34'd4194283;
			5'd9:  a = 34'd2097149;
			5'd10: a = 34'd1048576;
			5'd31: a = 34'd0;
			default: a = 34'd1 << (5'd30 - i);
		endcase
		return a;
	endfunction

endpackage

@@ rtl/gnss_fix_to_local_enu.sv @@
// Top level of the GNSS fix to local ENU offset block.
// Takes one beat at a time and delivers at most one result beat per input beat. A poll, a
// repeated time or a fix below 3D goes from the accepting cycle through a decide state and an
// emit state that loads the result register; a reset-origin beat ends after the decide state
// and gives no result. A 3D fix with the origin set runs the shared 37x18 multiplier, which
// forms the east factor, east and north in three rounds, before the emit state. The first 3D
// fix after reset or a reset-origin beat first runs a reciprocal division for the angle,
// CORDIC_STEPS CORDIC rotations and a state that keeps the cosine. While the previous
// result is stalled the block waits in its emit state. A new beat is taken once the previous
// result sits in the output register.
module gnss_fix_to_local_enu
	import gfe_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [29:0]        time_of_week_ms,
	input  logic [2:0]         fix_kind,
	input  logic signed [30:0] latitude_e7,
	input  logic signed [31:0] longitude_e7,
	input  logic signed [27:0] altitude_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               fresh,
	output logic               valid_res,
	output logic [29:0]        solution_time_ms,
	output logic signed [36:0] east_mm,
	output logic signed [35:0] north_mm,
	output logic signed [27:0] up_mm
);

	gfe_cmd_t  cmd;
	gfe_stat_t stat;

	// Sequencer.
	gfe_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	gfe_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.kind             (kind),
		.time_of_week_ms  (time_of_week_ms),
		.fix_kind         (fix_kind),
		.latitude_e7      (latitude_e7),
		.longitude_e7     (longitude_e7),
		.altitude_mm      (altitude_mm),
		.fresh            (fresh),
		.valid_res        (valid_res),
		.solution_time_ms (solution_time_ms),
		.east_mm          (east_mm),
		.north_mm         (north_mm),
		.up_mm            (up_mm)
	);

endmodule

@@ rtl/gfe_ctrl.sv @@
// Controller state machine that sequences the GNSS fix to local ENU datapath.
module gfe_ctrl
	import gfe_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  gfe_stat_t stat,
	output gfe_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_CORD   = 3'd3;
	localparam logic [2:0] ST_CLAT   = 3'd4;
	localparam logic [2:0] ST_MUL    = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	localparam logic [IDX_W-1:0] DIV_LAST  = IDX_W'(2);
	localparam logic [IDX_W-1:0] CORD_LAST = IDX_W'(CORDIC_STEPS - 1);
	localparam logic [IDX_W-1:0] MUL_LAST  = IDX_W'(2);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [1:0]       mop_q, mop_d;
	logic [1:0]       res_q, res_d;
	logic             out_valid_q;
	logic             out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		mop_d   = mop_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.idx    = idx_q;
		cmd.mul_op = mop_q;
		cmd.res    = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				idx_d = '0;
				if (stat.kind == KIND_RST) begin
					cmd.clear = 1'b1;
					state_d = ST_IDLE;
				end else if (stat.kind != KIND_SOL || stat.tow_same) begin
					res_d = RES_ZERO;
					state_d = ST_EMIT;
				end else begin
					cmd.set_prev = 1'b1;
					if (!stat.fix_3d) begin
						res_d = RES_TIME;
						state_d = ST_EMIT;
					end else if (!stat.origin_set) begin
						cmd.latch_origin = 1'b1;
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						mop_d = MOP_G;
						state_d = ST_MUL;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (idx_q == DIV_LAST) begin
					idx_d = '0;
					state_d = ST_CORD;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CORD: begin
				cmd.cord_step = 1'b1;
				if (idx_q == CORD_LAST) begin
					idx_d = '0;
					state_d = ST_CLAT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CLAT: begin
				cmd.cos_load = 1'b1;
				mop_d = MOP_G;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (idx_q == MUL_LAST) begin
					idx_d = '0;
					if (mop_q == MOP_G) begin
						mop_d = MOP_E;
					end else if (mop_q == MOP_E) begin
						mop_d = MOP_N;
					end else begin
						res_d = RES_FULL;
						state_d = ST_EMIT;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			mop_q       <= MOP_G;
			res_q       <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			mop_q   <= mop_d;
			res_q   <= res_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/gfe_datapath.sv @@
// Datapath: origin state, constant divider, CORDIC, shared multiplier and result register.
module gfe_datapath
	import gfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  gfe_cmd_t           cmd,
	output gfe_stat_t          stat,
	input  logic [1:0]         kind,
	input  logic [29:0]        time_of_week_ms,
	input  logic [2:0]         fix_kind,
	input  logic signed [30:0] latitude_e7,
	input  logic signed [31:0] longitude_e7,
	input  logic signed [27:0] altitude_mm,
	output logic               fresh,
	output logic               valid_res,
	output logic [29:0]        solution_time_ms,
	output logic signed [36:0] east_mm,
	output logic signed [35:0] north_mm,
	output logic signed [27:0] up_mm
);

	// Input beat registers.
	logic [1:0]         kind_q;
	logic [29:0]        tow_q;
	logic [2:0]         fix_q;
	logic signed [30:0] lat_q;
	logic signed [31:0] lon_q;
	logic signed [27:0] alt_q;

	// Origin state.
	logic               org_set_q;
	logic signed [30:0] org_lat_q;
	logic signed [31:0] org_lon_q;
	logic signed [27:0] org_alt_q;
	logic signed [31:0] org_cos_q;
	logic [29:0]        prev_q;

	// Divider and CORDIC registers.
	logic [61:0]        num_q;
	logic [30:0]        qe_q;
	logic [32:0]        rem_q;
	logic signed [33:0] x_q, y_q, z_q;

	// Multiplier registers.
	logic [71:0]        acc_q;
	logic [36:0]        g_q;
	logic signed [36:0] east_q;
	logic signed [35:0] north_q;

	// Output register.
	logic               fresh_q, valid_res_q;
	logic [29:0]        time_q;
	logic signed [36:0] east_o_q;
	logic signed [35:0] north_o_q;
	logic signed [27:0] up_o_q;

	assign stat.kind       = kind_q;
	assign stat.tow_same   = (tow_q == prev_q);
	assign stat.fix_3d     = (fix_q >= FIX_3D);
	assign stat.origin_set = org_set_q;

	// Saturated latitude magnitude in 1e-7 degree and the radian numerator.
	logic [30:0] lat_mag;
	logic [29:0] lat_sat;
	logic [61:0] num;
	assign lat_mag = lat_q[30] ? 31'(-lat_q) : 31'(lat_q);
	assign lat_sat = (lat_mag > {1'b0, LAT_MAX}) ? LAT_MAX : lat_mag[29:0];
	assign num     = 62'(lat_sat) * 62'(PI_Q30) + LAT_HALF;

	// Division by the half-turn constant: a reciprocal estimate that is at most two low,
	// the remainder left by that estimate, then the final correction.
	logic [63:0] qe_prod;
	logic [61:0] qd;
	logic [1:0]  qcorr;
	assign qe_prod = 64'(num_q[61:30]) * 64'(LAT_RECIP);
	assign qd      = 62'(qe_q) * 62'(LAT_FULL);
	assign qcorr   = (rem_q >= {1'b0, LAT_FULL, 1'b0}) ? 2'd2 :
		((rem_q >= {2'b00, LAT_FULL}) ? 2'd1 : 2'd0);

	// One CORDIC rotation step.
	logic signed [33:0] cdx, cdy, cang;
	assign cdx  = y_q >>> cmd.idx;
	assign cdy  = x_q >>> cmd.idx;
	assign cang = $signed(atan_q30(cmd.idx));

	// Differences from the origin.
	logic signed [32:0] dlon, dlat;
	logic [32:0]        dlon_mag, dlat_mag;
	logic [31:0]        cos_mag;
	logic signed [28:0] dup;
	assign dlon     = 33'(lon_q) - 33'(org_lon_q);
	assign dlat     = 33'(lat_q) - 33'(org_lat_q);
	assign dlon_mag = dlon[32] ? 33'(-dlon) : 33'(dlon);
	assign dlat_mag = dlat[32] ? 33'(-dlat) : 33'(dlat);
	assign cos_mag  = org_cos_q[31] ? 32'(-org_cos_q) : 32'(org_cos_q);
	assign dup      = 29'(alt_q) - 29'(org_alt_q);

	// Shared multiplier operand selection, one 18-bit slice of B per cycle.
	logic [36:0] mul_a;
	logic [35:0] mul_b;
	logic [17:0] mul_bs;
	logic [54:0] prod;
	always_comb begin
		unique case (cmd.mul_op)
			MOP_G: begin
				mul_a = K_MM_Q32;
				mul_b = 36'(cos_mag);
			end
			MOP_E: begin
				mul_a = g_q;
				mul_b = 36'(dlon_mag);
			end
			default: begin
				mul_a = K_MM_Q32;
				mul_b = 36'(dlat_mag);
			end
		endcase
	end
	assign mul_bs = cmd.idx[0] ? mul_b[35:18] : mul_b[17:0];
	assign prod   = mul_a * 55'(mul_bs);

	// Rounding of the finished product.
	logic [71:0] rnd_g, rnd_o;
	logic [39:0] omag;
	logic        e_neg, n_neg;
	assign rnd_g = acc_q + (72'd1 << 29);
	assign rnd_o = acc_q + (72'd1 << 31);
	assign omag  = rnd_o[71:32];
	assign e_neg = dlon[32] ^ org_cos_q[31];
	assign n_neg = dlat[32];

	// Input beat and origin state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_set_q <= 1'b0;
			org_lat_q <= '0;
			org_lon_q <= '0;
			org_alt_q <= '0;
			org_cos_q <= '0;
			prev_q    <= '0;
		end else begin
			if (cmd.clear) begin
				org_set_q <= 1'b0;
				org_lat_q <= '0;
				org_lon_q <= '0;
				org_alt_q <= '0;
				org_cos_q <= '0;
				prev_q    <= '0;
			end
			if (cmd.set_prev) begin
				prev_q <= tow_q;
			end
			if (cmd.latch_origin) begin
				org_set_q <= 1'b1;
				org_lat_q <= lat_q;
				org_lon_q <= lon_q;
				org_alt_q <= alt_q;
			end
			if (cmd.cos_load) begin
				org_cos_q <= x_q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			tow_q  <= time_of_week_ms;
			fix_q  <= fix_kind;
			lat_q  <= latitude_e7;
			lon_q  <= longitude_e7;
			alt_q  <= altitude_mm;
		end
	end

	// Divider feeding the CORDIC angle, then the CORDIC rotations.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= num;
			x_q   <= GAIN_Q30;
			y_q   <= '0;
			z_q   <= '0;
		end else if (cmd.div_step) begin
			if (cmd.idx == IDX_W'(0)) begin
				qe_q <= qe_prod[62:32];
			end else if (cmd.idx == IDX_W'(1)) begin
				rem_q <= 33'(num_q - qd);
			end else begin
				z_q <= 34'(qe_q) + 34'(qcorr);
			end
		end else if (cmd.cord_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - cdx;
				y_q <= y_q + cdy;
				z_q <= z_q - cang;
			end else begin
				x_q <= x_q + cdx;
				y_q <= y_q - cdy;
				z_q <= z_q + cang;
			end
		end
	end

	// Shared multiplier: two partial products, then round (and saturate for east and north).
	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			if (cmd.idx == IDX_W'(0)) begin
				acc_q <= 72'(prod);
			end else if (cmd.idx == IDX_W'(1)) begin
				acc_q <= acc_q + (72'(prod) << 18);
			end else begin
				unique case (cmd.mul_op)
					MOP_G: begin
						g_q <= rnd_g[66:30];
					end
					MOP_E: begin
						if (e_neg) begin
							east_q <= (omag >= (40'd1 << 36)) ? {1'b1, 36'd0} : 37'(-omag);
						end else begin
							east_q <= (omag >= (40'd1 << 36)) ? {1'b0, {36{1'b1}}} : 37'(omag);
						end
					end
					default: begin
						if (n_neg) begin
							north_q <= (omag >= (40'd1 << 35)) ? {1'b1, 35'd0} : 36'(-omag);
						end else begin
							north_q <= (omag >= (40'd1 << 35)) ? {1'b0, {35{1'b1}}} : 36'(omag);
						end
					end
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fresh_q     <= (cmd.res != RES_ZERO);
			valid_res_q <= (cmd.res == RES_FULL);
			time_q      <= (cmd.res != RES_ZERO) ? tow_q : '0;
			if (cmd.res == RES_FULL) begin
				east_o_q  <= east_q;
				north_o_q <= north_q;
				if (dup[28] != dup[27]) begin
					up_o_q <= dup[28] ? {1'b1, 27'd0} : {1'b0, {27{1'b1}}};
				end else begin
					up_o_q <= dup[27:0];
				end
			end else begin
				east_o_q  <= '0;
				north_o_q <= '0;
				up_o_q    <= '0;
			end
		end
	end

	assign fresh            = fresh_q;
	assign valid_res        = valid_res_q;
	assign solution_time_ms = time_q;
	assign east_mm          = east_o_q;
	assign north_mm         = north_o_q;
	assign up_mm            = up_o_q;

endmodule
